// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of the dilation block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define EGD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("egd assertion failed");

// The consequent is checked in the cycle after the antecedent.
`define EGD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("egd assertion failed");

`endif

// ===== hw/rtl/egd_pkg.sv =====
// Package of the elliptical grayscale dilation block.
// Holds field widths, register indexes and the state types; depends on nothing.
package egd_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 11;
	localparam int RAD_REG_W = 6;
	localparam int WID_REG_W = 11;
	localparam int ROW_W = 16;
	localparam logic [ROW_W-1:0] ROW_MAX = '1;

	localparam logic [CFG_IW-1:0] REG_RX = 2'd0;
	localparam logic [CFG_IW-1:0] REG_RY = 2'd1;
	localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WRITE,
		S_DX,
		S_RD,
		S_DRAIN,
		S_OUT,
		S_ADV
	} egd_state_t;

	typedef enum logic [2:0] {
		H_IDLE,
		H_AREA,
		H_RHS,
		H_T,
		H_CMP
	} egd_hstate_t;

endpackage

// ===== hw/rtl/egd_if.sv =====
// Valid/ready channel interfaces for pixels in and dilation results out.
// Depends on egd_pkg for the payload widths.
interface egd_pix_if import egd_pkg::*;;
	logic valid;
	logic ready;
	logic [PIX_W-1:0] pixel;
	logic frame_start;
	logic padding;

	modport source (output valid, pixel, frame_start, padding, input ready);
	modport sink (input valid, pixel, frame_start, padding, output ready);
endinterface

interface egd_res_if import egd_pkg::*;;
	logic valid;
	logic ready;
	logic [PIX_W-1:0] dilated;
	logic row_end;

	modport source (output valid, dilated, row_end, input ready);
	modport sink (input valid, dilated, row_end, output ready);
endinterface

// ===== hw/rtl/elliptical_grayscale_dilation.sv =====
// Grayscale dilation by an ellipse of radii rx and ry over a raster pixel stream.
// Each accepted pixel is written to a line store of 2*MAX_RADIUS+2 rows, and once ry+1 rows
// have arrived it yields the result for the pixel ry+1 rows above, scanned from the single-port
// line store one tap per cycle within a column. An item with a result runs, for each of the
// 2*rx+1 columns, one set-up step and then 2*h+1 reads, h being that column's height, and its
// result waits as long as the receiver holds off. A pixel with frame_start set first clears
// the whole line store, one entry per cycle, and the same pass runs after reset. Writing a
// radius recomputes the ellipse heights, while no pixel is taken.
module elliptical_grayscale_dilation import egd_pkg::*; #(
	parameter int MAX_RADIUS = 32,
	parameter int MAX_WIDTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	egd_pix_if.sink           pixels,
	egd_res_if.source         results,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int HIW = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
	localparam int DW = RW + 1;
	localparam int RING = 2 * MAX_RADIUS + 2;
	localparam int SW = $clog2(RING);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int XW = ((CW > RW) ? CW : RW) + 2;
	localparam int DEPTH = RING * MAX_WIDTH;
	localparam int AW = $clog2(DEPTH);

	egd_state_t state_q, state_d;

	logic [RAD_REG_W-1:0] rad_h_q, rad_v_q;
	logic [WID_REG_W-1:0] width_q;
	logic [RW-1:0] rx_e, ry_e;
	logic [WW-1:0] w_e, wm1, colc;

	logic item_q;
	logic [PIX_W-1:0] pix_q;
	logic [CW-1:0] col_q, colc_q, cc_q;
	logic [ROW_W-1:0] row_q;
	logic [SW-1:0] slot_q, k_q, kend_q;
	logic last_q;
	logic signed [DW-1:0] dx_q;
	logic [AW-1:0] clr_addr_q;
	logic [PIX_W-1:0] best_q;
	logic rv_s1;
	logic ov_q, rend_q;
	logic [PIX_W-1:0] dout_q;

	logic h_busy, h_start;
	logic [HIW-1:0] h_idx;
	logic [RW-1:0] h_rd, h_sel;
	logic [RW-1:0] ad;
	logic signed [XW-1:0] cpos, wlim;
	logic [SW:0] stmp;
	logic [SW-1:0] rslot;
	logic accept, out_load;

	logic ram_en, ram_we;
	logic [AW-1:0] ram_addr;
	logic [PIX_W-1:0] ram_wdata, ram_rdata;

	assign rx_e = (rad_h_q == '0) ? RW'(1) :
		(int'(rad_h_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_h_q);
	assign ry_e = (rad_v_q == '0) ? RW'(1) :
		(int'(rad_v_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_v_q);
	assign w_e = (width_q == '0) ? WW'(1) :
		(int'(width_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_q);
	assign wm1 = w_e - WW'(1);
	assign colc = ({1'b0, col_q} > wm1) ? wm1 : {1'b0, col_q};

	assign accept = pixels.valid && pixels.ready;
	assign pixels.ready = (state_q == S_IDLE) && !h_busy;
	assign h_start = cfg_we && (cfg_index == REG_RX || cfg_index == REG_RY);

	assign ad = (dx_q < 0) ? RW'(-dx_q) : RW'(dx_q);
	assign h_idx = HIW'(ad - RW'(1));
	assign h_sel = (ad == '0) ? ry_e : h_rd;
	assign cpos = $signed({{(XW-CW){1'b0}}, colc_q}) + XW'(dx_q);
	assign wlim = $signed({{(XW-WW){1'b0}}, wm1});

	assign stmp = {1'b0, slot_q} + (SW+1)'(RING) - {1'b0, k_q};
	assign rslot = (stmp >= (SW+1)'(RING)) ? SW'(stmp - (SW+1)'(RING)) : SW'(stmp);

	assign out_load = (state_q == S_OUT) && (!ov_q || results.ready);
	assign results.valid = ov_q;
	assign results.dilated = dout_q;
	assign results.row_end = rend_q;

	egd_heights #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_heights (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (h_start),
		.rx     (rx_e),
		.ry     (ry_e),
		.rd_idx (h_idx),
		.rd_h   (h_rd),
		.busy   (h_busy)
	);

	egd_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_line_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		ram_en = 1'b0;
		ram_we = 1'b0;
		ram_addr = '0;
		ram_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
				ram_addr = clr_addr_q;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = item_q ? S_WRITE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = pixels.frame_start ? S_CLEAR : S_WRITE;
				end
			end
			S_WRITE: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
				ram_addr = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(colc);
				ram_wdata = pix_q;
				state_d = (row_q >= ROW_W'(ry_e) + ROW_W'(1)) ? S_DX : S_ADV;
			end
			S_DX: state_d = S_RD;
			S_RD: begin
				ram_en = 1'b1;
				ram_addr = AW'(rslot) * AW'(MAX_WIDTH) + AW'(cc_q);
				if (k_q == kend_q) begin
					state_d = (dx_q == $signed({1'b0, rx_e})) ? S_DRAIN : S_DX;
				end
			end
			S_DRAIN: state_d = S_OUT;
			S_OUT: begin
				if (out_load) begin
					state_d = S_ADV;
				end
			end
			S_ADV: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			rad_h_q <= RAD_REG_W'(1);
			rad_v_q <= RAD_REG_W'(1);
			width_q <= WID_REG_W'(1);
			item_q <= 1'b0;
			clr_addr_q <= '0;
			col_q <= '0;
			row_q <= '0;
			slot_q <= '0;
			ov_q <= 1'b0;
			rv_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1 <= (state_q == S_RD);
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RX: rad_h_q <= cfg_wdata[RAD_REG_W-1:0];
					REG_RY: rad_v_q <= cfg_wdata[RAD_REG_W-1:0];
					REG_IMAGE_WIDTH: width_q <= cfg_wdata[WID_REG_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				item_q <= 1'b1;
			end else if (state_q == S_ADV) begin
				item_q <= 1'b0;
			end
			if (state_q == S_CLEAR) begin
				clr_addr_q <= (clr_addr_q == AW'(DEPTH - 1)) ? '0 : clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					col_q <= '0;
					row_q <= '0;
					slot_q <= '0;
				end
			end
			if (state_q == S_ADV) begin
				if (last_q) begin
					col_q <= '0;
					if (row_q != ROW_MAX) begin
						row_q <= row_q + ROW_W'(1);
					end
					slot_q <= (slot_q == SW'(RING - 1)) ? '0 : slot_q + SW'(1);
				end else begin
					col_q <= colc_q + CW'(1);
				end
			end
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pixels.padding ? '0 : pixels.pixel;
		end
		if (state_q == S_WRITE) begin
			colc_q <= CW'(colc);
			last_q <= (colc == wm1);
			dx_q <= -$signed({1'b0, rx_e});
			best_q <= '0;
		end else if (rv_s1 && ram_rdata > best_q) begin
			best_q <= ram_rdata;
		end
		if (state_q == S_DX) begin
			k_q <= SW'(ry_e) + SW'(1) - SW'(h_sel);
			kend_q <= SW'(ry_e) + SW'(1) + SW'(h_sel);
			if (cpos < 0) begin
				cc_q <= '0;
			end else if (cpos > wlim) begin
				cc_q <= CW'(wm1);
			end else begin
				cc_q <= CW'(cpos);
			end
		end
		if (state_q == S_RD) begin
			if (k_q == kend_q) begin
				dx_q <= dx_q + DW'(1);
			end else begin
				k_q <= k_q + SW'(1);
			end
		end
		if (out_load) begin
			dout_q <= best_q;
			rend_q <= last_q;
		end
	end

endmodule

// ===== hw/rtl/egd_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module egd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hw/rtl/egd_heights.sv =====
// Sequential unit that computes the ellipse column heights from the radii.
// Depends on egd_pkg; each compare of squared products follows its own H_T product step.
module egd_heights import egd_pkg::*; #(
	parameter int MAX_RADIUS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [$clog2(MAX_RADIUS+1)-1:0] rx,
	input  logic [$clog2(MAX_RADIUS+1)-1:0] ry,
	input  logic [((MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1)-1:0] rd_idx,
	output logic [$clog2(MAX_RADIUS+1)-1:0] rd_h,
	output logic                          busy
);

	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int HIW = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
	localparam int AW2 = 2 * RW + 2;
	localparam int TW = 2 * RW + 1;
	localparam int RHW = 4 * RW + 2;

	egd_hstate_t state_q, state_d;
	logic [RW-1:0] d_q;
	logic [RW-1:0] k_q;
	logic [RW-1:0] h_q;
	logic [AW2-1:0] area_q;
	logic [2*RW-1:0] ry2_q;
	logic [RHW-1:0] rhs_q;
	logic [TW-1:0] t_q;
	logic [RW-1:0] height_q [MAX_RADIUS];

	logic [RW:0] od;
	logic [2*RW-1:0] rxsq;
	logic [RHW-1:0] tsq;
	logic hit;
	logic [RW-1:0] hn;

	assign od = {d_q, 1'b0} - (RW+1)'(1);
	assign rxsq = (2*RW)'(rx) * (2*RW)'(rx);
	assign tsq = RHW'(t_q) * RHW'(t_q);
	assign hit = (tsq <= rhs_q);
	assign hn = hit ? k_q : h_q;
	assign busy = (state_q != H_IDLE);
	assign rd_h = height_q[rd_idx];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			H_IDLE: state_d = H_IDLE;
			H_AREA: state_d = H_RHS;
			H_RHS: state_d = H_T;
			H_T: state_d = H_CMP;
			H_CMP: begin
				if (k_q == ry) begin
					state_d = (d_q == rx) ? H_IDLE : H_AREA;
				end else begin
					state_d = H_T;
				end
			end
			default: state_d = H_IDLE;
		endcase
		if (start) begin
			state_d = H_AREA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_AREA;
			d_q <= RW'(1);
		end else begin
			state_q <= state_d;
			if (start) begin
				d_q <= RW'(1);
			end else if (state_q == H_CMP && k_q == ry && d_q != rx) begin
				d_q <= d_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			H_AREA: begin
				area_q <= {rxsq, 2'b00} - AW2'(od) * AW2'(od);
				ry2_q <= (2*RW)'(ry) * (2*RW)'(ry);
				k_q <= RW'(1);
				h_q <= '0;
			end
			H_RHS: rhs_q <= RHW'(ry2_q) * RHW'(area_q);
			H_T: t_q <= TW'(rx) * TW'({k_q, 1'b0} - (RW+1)'(1));
			H_CMP: begin
				h_q <= hn;
				if (k_q == ry) begin
					height_q[HIW'(d_q - RW'(1))] <= hn;
				end else begin
					k_q <= k_q + RW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/egd_checker.sv =====
// Port-level checker for the dilation block, bound to the top level.
// Depends on assert_macros.svh and egd_pkg.
`include "assert_macros.svh"

module egd_checker import egd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PIX_W-1:0] dilated
);

	`EGD_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready)
	`EGD_ASSERT_SAME(a_no_result_right_after_transfer, $rose(out_valid),
		!$past(in_valid && in_ready))
	`EGD_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(dilated))

endmodule

bind elliptical_grayscale_dilation egd_checker u_egd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.dilated   (results.dilated)
);

// ===== tb/sv/elliptical_grayscale_dilation_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the elliptical grayscale dilation block.
// Needs egd_pkg, the channel interfaces in egd_if and the block itself.
module elliptical_grayscale_dilation_tb;
	import egd_pkg::*;

	localparam int RING = 66;
	localparam int MW = 1024;
	localparam int RMAX = 32;
	localparam int ITEM_TARGET = 700;
	localparam longint CYCLE_LIMIT = 64000000;
	localparam logic [CFG_IW-1:0] REG_NONE = 2'd3;

	typedef struct {
		logic [PIX_W-1:0] dilated;
		logic row_end;
	} dil_result_t;

	class egd_scoreboard;
		logic [PIX_W-1:0] line_mem [RING*MW];
		int heights [RMAX+1];
		int rx_reg, ry_reg, w_reg;
		int col, row, slot;
		dil_result_t dil_q [$];
		int errors;

		function int rx_eff();
			return rx_reg < 1 ? 1 : (rx_reg > RMAX ? RMAX : rx_reg);
		endfunction

		function int ry_eff();
			return ry_reg < 1 ? 1 : (ry_reg > RMAX ? RMAX : ry_reg);
		endfunction

		function int w_eff();
			return w_reg < 1 ? 1 : (w_reg > MW ? MW : w_reg);
		endfunction

		function void make_heights();
			longint rx, ry, span, lim, t;
			rx = rx_eff();
			ry = ry_eff();
			foreach (heights[i]) heights[i] = 0;
			heights[0] = int'(ry);
			for (int d = 1; d <= rx; d++) begin
				span = 4 * rx * rx - (2 * d - 1) * (2 * d - 1);
				lim = ry * ry * span;
				for (int k = 1; k <= ry; k++) begin
					t = rx * (2 * k - 1);
					if (t * t <= lim) heights[d] = k;
				end
			end
		endfunction

		function void clear_frame();
			foreach (line_mem[i]) line_mem[i] = '0;
			col = 0;
			row = 0;
			slot = 0;
		endfunction

		function new();
			rx_reg = 1;
			ry_reg = 1;
			w_reg = 1;
			errors = 0;
			clear_frame();
			make_heights();
		endfunction

		function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
			case (idx)
				REG_RX: begin
					rx_reg = int'(val[RAD_REG_W-1:0]);
					make_heights();
				end
				REG_RY: begin
					ry_reg = int'(val[RAD_REG_W-1:0]);
					make_heights();
				end
				REG_IMAGE_WIDTH: w_reg = int'(val[WID_REG_W-1:0]);
				default: ;
			endcase
		endfunction

		function logic [PIX_W-1:0] max_over_ellipse(int x);
			int rx, ry, w, c, h, s;
			logic [PIX_W-1:0] best;
			rx = rx_eff();
			ry = ry_eff();
			w = w_eff();
			best = '0;
			for (int dx = -rx; dx <= rx; dx++) begin
				c = x + dx;
				h = heights[dx < 0 ? -dx : dx];
				if (c < 0) c = 0;
				if (c > w - 1) c = w - 1;
				for (int k = ry + 1 - h; k <= ry + 1 + h; k++) begin
					s = (slot + RING - k) % RING;
					if (line_mem[s*MW + c] > best) best = line_mem[s*MW + c];
				end
			end
			return best;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] pix, logic fs, logic pad);
			int w, x;
			dil_result_t r;
			w = w_eff();
			if (pad) pix = '0;
			if (fs) clear_frame();
			x = col > w - 1 ? w - 1 : col;
			line_mem[slot*MW + x] = pix;
			if (row >= ry_eff() + 1) begin
				r.dilated = max_over_ellipse(x);
				r.row_end = (x == w - 1);
				dil_q.push_back(r);
			end
			if (x == w - 1) begin
				col = 0;
				if (row < int'(ROW_MAX)) row++;
				slot = (slot + 1) % RING;
			end else begin
				col = x + 1;
			end
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(logic [PIX_W-1:0] dil, logic re);
			dil_result_t e;
			if (dil_q.size() == 0) begin
				report($sformatf("unexpected result dilated=%0d row_end=%0b", dil, re));
			end else begin
				e = dil_q.pop_front();
				if (dil !== e.dilated)
					report($sformatf("dilated %0d, expected %0d", dil, e.dilated));
				if (re !== e.row_end)
					report($sformatf("row_end %0b, expected %0b", re, e.row_end));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_wdata;
	longint cycles;
	int items_sent;
	bit hold_arm;
	bit src_quiet, snk_quiet;
	egd_scoreboard sb;

	egd_pix_if pix ();
	egd_res_if res ();

	elliptical_grayscale_dilation dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix),
		.results(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function int gap_len(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if ($urandom_range(0, 399) == 0) src_quiet <= ~src_quiet;
		if ($urandom_range(0, 399) == 0) snk_quiet <= ~snk_quiet;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (res.valid && res.ready) sb.check_result(res.dilated, res.row_end);
	end

	initial begin : result_sink
		int stall;
		int hold_cycles;
		stall = 0;
		hold_cycles = 0;
		forever begin
			@(negedge clk);
			if (hold_arm && res.valid) begin
				hold_arm = 1'b0;
				hold_cycles = 5000;
			end
			if (hold_cycles > 0) begin
				res.ready = 1'b0;
				hold_cycles--;
			end else if (stall > 0) begin
				res.ready = 1'b0;
				stall--;
			end else begin
				res.ready = 1'b1;
				stall = gap_len(snk_quiet);
			end
		end
	end

	task send_pixel(logic [PIX_W-1:0] p, logic fs, logic pad);
		int g;
		g = gap_len(src_quiet);
		@(negedge clk);
		repeat (g) begin
			pix.valid = 1'b0;
			@(negedge clk);
		end
		pix.valid = 1'b1;
		pix.pixel = p;
		pix.frame_start = fs;
		pix.padding = pad;
		do @(posedge clk); while (!pix.ready);
		sb.note_pixel(p, fs, pad);
		items_sent++;
	endtask

	task settle();
		@(negedge clk);
		pix.valid = 1'b0;
		while (sb.dil_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, val);
		if (idx != REG_IMAGE_WIDTH)
			repeat (2 * sb.rx_eff() * (sb.ry_eff() + 2) + 40) @(posedge clk);
	endtask

	function logic [PIX_W-1:0] random_pixel();
		if ($urandom_range(0, 3) == 0) return PIX_W'($urandom_range(0, 255));
		return PIX_W'($urandom_range(0, 15));
	endfunction

	task send_frame(int rows, int extra, bit fs_first, bit noisy);
		int w;
		w = sb.w_eff();
		for (int i = 0; i < rows * w; i++)
			send_pixel(random_pixel(), fs_first && i == 0,
				noisy && $urandom_range(0, 19) == 0);
		for (int i = 0; i < (sb.ry_eff() + 1 + extra) * w; i++)
			send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		pix.valid = 1'b0;
		pix.pixel = '0;
		pix.frame_start = 1'b0;
		pix.padding = 1'b0;
		res.ready = 1'b0;
		cycles = 0;
		items_sent = 0;
		hold_arm = 1'b0;
		src_quiet = 1'b0;
		snk_quiet = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: a one-pixel-wide image, padding with frame start, extra flush rows.
		send_pixel(8'h00, 1'b1, 1'b0);
		send_pixel(8'hFF, 1'b0, 1'b0);
		send_pixel(8'hAA, 1'b0, 1'b0);
		send_pixel(8'h55, 1'b0, 1'b0);
		send_pixel(8'hFF, 1'b0, 1'b1);
		send_pixel(8'h80, 1'b0, 1'b0);
		send_pixel(8'hFF, 1'b1, 1'b1);
		send_pixel(8'h01, 1'b0, 1'b0);
		send_pixel(8'hFE, 1'b0, 1'b0);
		repeat (4) send_pixel(8'h7F, 1'b0, 1'b1);
		settle();

		// Largest radii.
		write_cfg(REG_RX, 11'd32);
		write_cfg(REG_RY, 11'd32);
		write_cfg(REG_IMAGE_WIDTH, 11'd3);
		send_frame(3, 0, 1'b1, 1'b0);
		settle();

		// Out-of-range register values are clamped.
		write_cfg(REG_RX, 11'd0);
		write_cfg(REG_RY, 11'd63);
		write_cfg(REG_IMAGE_WIDTH, 11'd0);
		send_frame(2, 1, 1'b1, 1'b0);
		settle();
		write_cfg(REG_NONE, 11'h7FF);

		// Width grown to beyond its maximum and then shrunk in the middle of a row.
		write_cfg(REG_RX, 11'd3);
		write_cfg(REG_RY, 11'd1);
		write_cfg(REG_IMAGE_WIDTH, 11'd4);
		for (int i = 0; i < 14; i++) send_pixel(random_pixel(), i == 0, 1'b0);
		settle();
		write_cfg(REG_IMAGE_WIDTH, 11'h7FF);
		repeat (3) send_pixel(random_pixel(), 1'b0, 1'b0);
		settle();
		write_cfg(REG_IMAGE_WIDTH, 11'd1);
		send_pixel(8'hC3, 1'b0, 1'b0);
		repeat (3) send_pixel(8'h3C, 1'b0, 1'b1);
		settle();

		// Random frames; the first waiting result meets a long receiver hold-off.
		hold_arm = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			write_cfg(REG_RX, CFG_DW'(($urandom_range(0, 9) == 0) ?
				$urandom_range(9, 32) : $urandom_range(1, 8)));
			write_cfg(REG_RY, CFG_DW'(($urandom_range(0, 9) == 0) ?
				$urandom_range(5, 12) : $urandom_range(1, 4)));
			write_cfg(REG_IMAGE_WIDTH, CFG_DW'($urandom_range(1, 16)));
			send_frame($urandom_range(1, 8), $urandom_range(0, 2),
				$urandom_range(0, 2) == 0, 1'b1);
			settle();
		end

		settle();
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
